>>> sv/dhcp_reply_filter_parser_macros.svh
// assertion macros for the dhcp reply filter parser
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef DHCP_REPLY_FILTER_PARSER_MACROS_SVH
`define DHCP_REPLY_FILTER_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, off during reset
`define DRFP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define DRFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DRFP_ASSERT_NOW(label, clk, rst, ante, cons)
`define DRFP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/dhcp_rfp_pkg.sv
// shared types and constants for the dhcp reply filter parser
// no dependencies
package dhcp_rfp_pkg;

  localparam int COUNT_W = 10;
  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t MAX_FRAME = count_t'(768);
  localparam count_t OPT_BASE  = count_t'(268);
  localparam count_t MIN_UDP   = count_t'(28);

  // capture positions in the frame
  localparam count_t POS_VER_IHL = count_t'(0);
  localparam count_t POS_TLEN_HI = count_t'(2);
  localparam count_t POS_TLEN_LO = count_t'(3);
  localparam count_t POS_PROTO   = count_t'(9);
  localparam count_t POS_SRC_LO  = count_t'(12);
  localparam count_t POS_SRC_HI  = count_t'(15);
  localparam count_t POS_DPORT_A = count_t'(22);
  localparam count_t POS_DPORT_B = count_t'(23);
  localparam count_t POS_ULEN_A  = count_t'(24);
  localparam count_t POS_ULEN_B  = count_t'(25);
  localparam count_t POS_XID_LO  = count_t'(32);
  localparam count_t POS_XID_HI  = count_t'(35);
  localparam count_t POS_YIP_LO  = count_t'(44);
  localparam count_t POS_YIP_HI  = count_t'(47);
  localparam count_t POS_COOK_LO = count_t'(264);
  localparam count_t POS_COOK_HI = count_t'(267);

  localparam logic [15:0] IP_HDR       = 16'd20;
  localparam logic [15:0] OPT_BASE_LEN = 16'd268;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  VER_IHL5     = 8'h45;
  localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
  localparam logic [7:0]  CODE_MSGTYPE = 8'd53;
  localparam logic [7:0]  CODE_SERVER  = 8'd54;
  localparam logic [7:0]  SIZE_MSGTYPE = 8'd1;
  localparam logic [7:0]  SIZE_SERVER  = 8'd4;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SEEN_NOT = 2'd0,
    SEEN_OK  = 2'd1,
    SEEN_BAD = 2'd2
  } seen_t;

  typedef enum logic [2:0] {
    RSN_OK         = 3'd0,
    RSN_SHORT      = 3'd1,
    RSN_INCOMPLETE = 3'd2,
    RSN_BAD_HDR    = 3'd3,
    RSN_TRUNC      = 3'd4,
    RSN_BAD_ID     = 3'd5
  } reason_t;

  typedef enum logic {
    CFG_XID  = 1'b0,
    CFG_PORT = 1'b1
  } cfg_idx_t;

  localparam logic [15:0] CLIENT_PORT_RST = 16'd68;

  // per-frame parse state
  typedef struct packed {
    count_t      byte_count;
    logic [7:0]  ip_protocol;
    logic [7:0]  version_ihl;
    logic [15:0] ip_total_len;
    logic [15:0] udp_dest_port;
    logic [15:0] udp_length;
    logic [31:0] src_address;
    logic [31:0] echoed_xid;
    logic [31:0] offered_address;
    logic [31:0] cookie_word;
    phase_t      scan_phase;
    logic [7:0]  opt_code_held;
    logic [7:0]  opt_bytes_left;
    logic        scan_stopped;
    seen_t       type_found;
    logic [7:0]  type_value;
    seen_t       server_found;
    logic [31:0] server_value;
  } frame_t;

  localparam frame_t FRAME_CLEAR = '{
    byte_count: '0, ip_protocol: '0, version_ihl: '0, ip_total_len: '0,
    udp_dest_port: '0, udp_length: '0, src_address: '0, echoed_xid: '0,
    offered_address: '0, cookie_word: '0, scan_phase: PH_CODE,
    opt_code_held: '0, opt_bytes_left: '0, scan_stopped: 1'b0,
    type_found: SEEN_NOT, type_value: '0, server_found: SEEN_NOT,
    server_value: '0
  };

  typedef struct packed {
    logic        accepted;
    reason_t     reject_reason;
    logic [15:0] total_length;
    logic [7:0]  message_type;
    logic        server_id_valid;
    logic [31:0] server_id;
    logic [31:0] your_ip;
    logic [31:0] source_ip;
  } result_t;

endpackage

>>> sv/dhcp_rfp_parser.sv
// per-byte header capture and options walk for the dhcp reply filter parser
// depends on dhcp_rfp_pkg
module dhcp_rfp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                last,
  output dhcp_rfp_pkg::frame_t frame_next
);
  import dhcp_rfp_pkg::*;

  frame_t      frame;
  count_t      n;
  logic [16:0] opt_end;
  logic [16:0] code_end;
  logic [7:0]  left_dec;
  logic        is_type;
  logic        is_srv;

  always_comb begin
    frame_next = frame;
    n        = frame.byte_count;
    opt_end  = 17'(n) + 17'd1 + 17'(rx_byte);
    code_end = 17'(n) + 17'd2;
    left_dec = frame.opt_bytes_left - 8'd1;
    is_type  = (frame.opt_code_held == CODE_MSGTYPE) && (frame.type_found == SEEN_NOT);
    is_srv   = (frame.opt_code_held == CODE_SERVER) && (frame.server_found == SEEN_NOT);
    if (n < MAX_FRAME) begin
      // fixed-position header capture
      if (n == POS_VER_IHL) begin
        frame_next.version_ihl = rx_byte;
      end else if (n == POS_TLEN_HI || n == POS_TLEN_LO) begin
        frame_next.ip_total_len = {frame.ip_total_len[7:0], rx_byte};
      end else if (n == POS_PROTO) begin
        frame_next.ip_protocol = rx_byte;
      end else if (n >= POS_SRC_LO && n <= POS_SRC_HI) begin
        frame_next.src_address = {frame.src_address[23:0], rx_byte};
      end else if (n == POS_DPORT_A || n == POS_DPORT_B) begin
        frame_next.udp_dest_port = {frame.udp_dest_port[7:0], rx_byte};
      end else if (n == POS_ULEN_A || n == POS_ULEN_B) begin
        frame_next.udp_length = {frame.udp_length[7:0], rx_byte};
      end else if (n >= POS_XID_LO && n <= POS_XID_HI) begin
        frame_next.echoed_xid = {frame.echoed_xid[23:0], rx_byte};
      end else if (n >= POS_YIP_LO && n <= POS_YIP_HI) begin
        frame_next.offered_address = {frame.offered_address[23:0], rx_byte};
      end else if (n >= POS_COOK_LO && n <= POS_COOK_HI) begin
        frame_next.cookie_word = {frame.cookie_word[23:0], rx_byte};
      end

      // options walk
      if (n >= OPT_BASE && !frame.scan_stopped) begin
        unique case (frame.scan_phase)
          PH_LEN: begin
            if (opt_end > 17'(frame.ip_total_len)) begin
              frame_next.scan_stopped = 1'b1;
            end else begin
              if (is_type && rx_byte != SIZE_MSGTYPE) frame_next.type_found = SEEN_BAD;
              if (is_srv && rx_byte != SIZE_SERVER) frame_next.server_found = SEEN_BAD;
              frame_next.opt_bytes_left = rx_byte;
              frame_next.scan_phase = (rx_byte == 8'd0) ? PH_CODE : PH_DATA;
            end
          end
          PH_DATA: begin
            if (is_type) frame_next.type_value = rx_byte;
            if (is_srv) frame_next.server_value = {frame.server_value[23:0], rx_byte};
            frame_next.opt_bytes_left = left_dec;
            if (left_dec == 8'd0) begin
              if (is_type) frame_next.type_found = SEEN_OK;
              if (is_srv) frame_next.server_found = SEEN_OK;
              frame_next.scan_phase = PH_CODE;
            end
          end
          default: begin
            if (code_end > 17'(frame.ip_total_len)) begin
              frame_next.scan_stopped = 1'b1;
            end else begin
              frame_next.opt_code_held = rx_byte;
              frame_next.scan_phase = PH_LEN;
            end
          end
        endcase
      end
      frame_next.byte_count = n + count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= FRAME_CLEAR;
    end else if (step) begin
      frame <= last ? FRAME_CLEAR : frame_next;
    end
  end

endmodule

>>> sv/dhcp_rfp_verdict.sv
// end-of-frame checks and result assembly for the dhcp reply filter parser
// depends on dhcp_rfp_pkg
module dhcp_rfp_verdict (
  input  dhcp_rfp_pkg::frame_t  frame,
  input  logic [31:0]           transaction_id,
  input  logic [15:0]           client_port,
  output dhcp_rfp_pkg::result_t result
);
  import dhcp_rfp_pkg::*;

  reason_t reason;
  logic    hdr_bad;

  always_comb begin
    hdr_bad = (frame.ip_protocol != PROTO_UDP) || (frame.version_ihl != VER_IHL5) ||
              (frame.udp_dest_port != client_port) || (frame.ip_total_len < IP_HDR) ||
              (frame.udp_length != frame.ip_total_len - IP_HDR);
    if (frame.byte_count < MIN_UDP) begin
      reason = RSN_SHORT;
    end else if (16'(frame.byte_count) < frame.ip_total_len) begin
      reason = RSN_INCOMPLETE;
    end else if (hdr_bad) begin
      reason = RSN_BAD_HDR;
    end else if (frame.ip_total_len < OPT_BASE_LEN) begin
      reason = RSN_TRUNC;
    end else if (frame.cookie_word != MAGIC_COOKIE || frame.echoed_xid != transaction_id) begin
      reason = RSN_BAD_ID;
    end else begin
      reason = RSN_OK;
    end

    result.accepted        = (reason == RSN_OK);
    result.reject_reason   = reason;
    result.total_length    = frame.ip_total_len;
    result.message_type    = (frame.type_found == SEEN_OK) ? frame.type_value : 8'd0;
    result.server_id_valid = (frame.server_found == SEEN_OK);
    result.server_id       = (frame.server_found == SEEN_OK) ? frame.server_value : 32'd0;
    result.your_ip         = frame.offered_address;
    result.source_ip       = frame.src_address;
  end

endmodule

>>> sv/dhcp_reply_filter_parser.sv
// top level of the dhcp reply filter parser: stream ports, config registers, result register
// depends on dhcp_rfp_pkg, dhcp_rfp_parser, dhcp_rfp_verdict and the assertion macro header
//
// Receives an IPv4 frame one byte per request on the slave stream, with tlast on the final
// byte, and returns one result request per frame on the master stream. The block takes one
// byte every cycle: a byte lands in an input register, and as it moves on the parser updates
// its header captures and the options walk (code/length pairs from byte 268 up to the IP total
// length) in a single pass of short logic. On the final byte the checks run on the updated
// state and the verdict goes into the result register, so a result shows on m_tvalid once
// its last byte has passed the input register and the result register. Input stalls only when
// a final byte waits while an earlier result is still held on the master side. Bytes past 768
// are dropped from parsing. Checks, first failure wins: 1 fewer than 28 bytes, 2 fewer bytes
// than the IP total length, 3 bad IP/UDP header (protocol, version/IHL, destination port,
// total length below 20, UDP length), 4 total length below 268, 5 bad magic cookie or
// transaction id; 0 means accepted. Config registers: index 0 transaction id (reset 0),
// index 1 client UDP port (reset 68); write them only while no frame is in flight.
`include "dhcp_reply_filter_parser_macros.svh"

module dhcp_reply_filter_parser (
  input  logic         clk,
  input  logic         rst,
  // byte stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // rx_byte[7:0]
  input  logic         s_tlast,   // last
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // total_length[15:0], message_type[23:16],
                                  // server_id_valid[24], server_id[56:25],
                                  // your_ip[88:57], source_ip[120:89], zero fill
  output logic [3:0]   m_tuser,   // accepted[0], reject_reason[3:1]
  // config write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  import dhcp_rfp_pkg::*;

  // config registers
  logic [31:0] transaction_id;
  logic [15:0] client_port;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;

  // result register
  result_t result;
  result_t out_result;

  frame_t frame_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      transaction_id <= 32'd0;
      client_port    <= CLIENT_PORT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_XID:  transaction_id <= cfg_data;
        CFG_PORT: client_port    <= cfg_data[15:0];
        default:  ;
      endcase
    end
  end

  // a byte moves on unless it closes a frame while the result slot is full and not being taken
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  dhcp_rfp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .rx_byte    (in_byte),
    .last       (in_last),
    .frame_next (frame_next)
  );

  dhcp_rfp_verdict u_verdict (
    .frame          (frame_next),
    .transaction_id (transaction_id),
    .client_port    (client_port),
    .result         (result)
  );

  // result slot: a new frame end loads it, the downstream take empties it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_result <= result;
    end
  end

  assign m_tdata = {7'd0, out_result.source_ip, out_result.your_ip, out_result.server_id,
                    out_result.server_id_valid, out_result.message_type,
                    out_result.total_length};
  assign m_tuser = {out_result.reject_reason, out_result.accepted};

  // a frame end always shows up as a result in the next cycle
  `DRFP_ASSERT_NEXT(a_frame_end_loads, clk, rst, advance && in_last, m_tvalid)
  // accept flag and reason code agree
  `DRFP_ASSERT_NOW(a_accept_matches, clk, rst, m_tvalid,
                   m_tuser[0] == (out_result.reject_reason == RSN_OK))
  // no server id without a valid four-byte option
  `DRFP_ASSERT_NOW(a_server_id_zero, clk, rst, m_tvalid && !out_result.server_id_valid,
                   out_result.server_id == 32'd0)
  // byte count saturates at the frame limit
  `DRFP_ASSERT_NOW(a_count_bound, clk, rst, in_valid, frame_next.byte_count <= MAX_FRAME)

endmodule
